// ===== design/gtpu_hlp_pkg.sv =====
// gtpu_hlp_pkg: shared types and constants for the gtp-u header length parser
// no dependencies; imported by every module of the block

package gtpu_hlp_pkg;

    localparam int MAX_HEADER_BYTES_DEF = 1024;

    localparam logic [2:0] FLAG_MASK      = 3'h7;
    localparam int         FIXED_LEN      = 8;
    localparam int         FIXED_OPT_LEN  = 12;
    localparam int         EXT_SHIFT      = 2;
    localparam int         LEN_W          = 11;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_LEN = 2'd1;
    localparam logic [1:0] ST_EARLY    = 2'd2;
    localparam logic [1:0] ST_LONG     = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIXED,
        PH_EXTLEN,
        PH_EXTBODY
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_packet;
        logic       last_of_packet;
    } pkt_word_t;

    typedef struct packed {
        logic [LEN_W-1:0] header_length;
        logic [7:0]       message_type;
        logic [2:0]       option_flags;
        logic [1:0]       status;
    } hdr_word_t;

    typedef struct packed {
        logic      emit;
        hdr_word_t word;
    } parse_res_t;

endpackage

// ===== design/gtpu_hlp_in_reg.sv =====
// gtpu_hlp_in_reg: input register holding one packet byte word
// depends on gtpu_hlp_pkg

module gtpu_hlp_in_reg
    import gtpu_hlp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pkt_valid,
    output logic      pkt_stall,
    input  pkt_word_t pkt_word,
    input  logic      take,
    output logic      word_valid,
    output pkt_word_t word
);

    logic      valid_reg;
    logic      valid_next;
    pkt_word_t word_reg;

    assign pkt_stall  = valid_reg && !take;
    assign valid_next = pkt_stall ? valid_reg : pkt_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_valid && !pkt_stall)
        begin
            word_reg <= pkt_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

// ===== design/gtpu_hlp_parse.sv =====
// gtpu_hlp_parse: per-packet parse state and the one-pass header length logic
// depends on gtpu_hlp_pkg

module gtpu_hlp_parse
    import gtpu_hlp_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  pkt_word_t  word,
    output parse_res_t res
);

    localparam int POS_W = $clog2(MAX_HEADER_BYTES + 2);
    localparam int END_W = $clog2(MAX_HEADER_BYTES + 1021);

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       flags_reg, flags_next;
    logic [7:0]       mtype_reg, mtype_next;
    logic [POS_W-1:0] ext_end_reg, ext_end_next;

    logic             start;
    logic             active;
    phase_t           phase_cur;
    logic [POS_W-1:0] idx;
    logic [POS_W-1:0] pos_inc;
    logic [2:0]       flags_new;
    logic [7:0]       mtype_new;
    logic [POS_W-1:0] need;
    logic             fixed_done;
    logic             ext_done;
    logic [END_W-1:0] ext_end_calc;
    logic             too_long;
    logic             emit;
    logic [1:0]       status;
    logic [POS_W-1:0] len_sel;

    assign start     = word.first_of_packet;
    assign active    = fire && (start || (phase_reg != PH_IDLE));
    assign phase_cur = start ? PH_FIXED : phase_reg;
    assign idx       = start ? '0 : pos_reg;
    assign pos_inc   = idx + POS_W'(1);

    assign flags_new = (phase_cur == PH_FIXED && idx == '0) ? (word.data_byte[2:0] & FLAG_MASK)
                     : (start ? 3'd0 : flags_reg);
    assign mtype_new = (phase_cur == PH_FIXED && idx == POS_W'(1)) ? word.data_byte
                     : (start ? 8'd0 : mtype_reg);

    assign need       = (flags_new != 3'd0) ? POS_W'(FIXED_OPT_LEN) : POS_W'(FIXED_LEN);
    assign fixed_done = pos_inc >= need;
    assign ext_done   = pos_inc >= ext_end_reg;

    assign ext_end_calc = END_W'(idx) + END_W'({word.data_byte, 2'b00});
    assign too_long     = ext_end_calc > END_W'(MAX_HEADER_BYTES);

    // outputs
    always_comb
    begin
        emit    = 1'b0;
        status  = ST_OK;
        len_sel = '0;
        unique case (phase_cur)
            PH_FIXED:
            begin
                if (fixed_done && !(flags_new[2] && word.data_byte != 8'd0))
                begin
                    emit    = 1'b1;
                    len_sel = need;
                end
            end
            PH_EXTLEN:
            begin
                if (word.data_byte == 8'd0)
                begin
                    emit   = 1'b1;
                    status = ST_ZERO_LEN;
                end
                else if (too_long)
                begin
                    emit   = 1'b1;
                    status = ST_LONG;
                end
            end
            PH_EXTBODY:
            begin
                if (ext_done && word.data_byte == 8'd0)
                begin
                    emit    = 1'b1;
                    len_sel = ext_end_reg;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        if (!emit && word.last_of_packet)
        begin
            emit   = 1'b1;
            status = ST_EARLY;
        end
        emit = emit && active;
    end

    assign res.emit               = emit;
    assign res.word.header_length = (status == ST_OK) ? LEN_W'(len_sel) : '0;
    assign res.word.message_type  = mtype_new;
    assign res.word.option_flags  = flags_new;
    assign res.word.status        = status;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        flags_next   = flags_reg;
        mtype_next   = mtype_reg;
        ext_end_next = ext_end_reg;
        if (active)
        begin
            pos_next     = pos_inc;
            flags_next   = flags_new;
            mtype_next   = mtype_new;
            ext_end_next = start ? '0 : ext_end_reg;
            if (emit)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                unique case (phase_cur)
                    PH_FIXED:
                    begin
                        phase_next = fixed_done ? PH_EXTLEN : PH_FIXED;
                    end
                    PH_EXTLEN:
                    begin
                        phase_next   = PH_EXTBODY;
                        ext_end_next = ext_end_calc[POS_W-1:0];
                    end
                    PH_EXTBODY:
                    begin
                        phase_next = ext_done ? PH_EXTLEN : PH_EXTBODY;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pos_reg     <= '0;
            flags_reg   <= 3'd0;
            mtype_reg   <= 8'd0;
            ext_end_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            flags_reg   <= flags_next;
            mtype_reg   <= mtype_next;
            ext_end_reg <= ext_end_next;
        end
    end

endmodule

// ===== design/gtpu_hlp_out_reg.sv =====
// gtpu_hlp_out_reg: result register toward the header result channel
// depends on gtpu_hlp_pkg

module gtpu_hlp_out_reg
    import gtpu_hlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  parse_res_t res,
    output logic       ready,
    output logic       hdr_valid,
    input  logic       hdr_stall,
    output hdr_word_t  hdr_word
);

    logic      valid_reg;
    logic      valid_next;
    hdr_word_t word_reg;

    assign ready      = !valid_reg || !hdr_stall;
    assign valid_next = (ready && res.emit) ? 1'b1 : (ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && res.emit)
        begin
            word_reg <= res.word;
        end
    end

    assign hdr_valid = valid_reg;
    assign hdr_word  = word_reg;

endmodule

// ===== design/gtpu_header_length_parser.sv =====
// Takes a GTP-U packet one byte word per cycle while pkt_stall is low and gives
// one result word per packet: header length, message type, option flags and
// status. Sustained rate is one byte per cycle while hdr_stall is low. A byte is
// parsed combinationally from the input register; its result (if any) is
// registered in the result register and shows on hdr_valid. The rate is set by
// the single pass of compare-and-add logic between the input register and the
// result register; hdr_stall reaches pkt_stall through that pair combinationally.
// depends on gtpu_hlp_pkg, gtpu_hlp_in_reg, gtpu_hlp_parse, gtpu_hlp_out_reg

module gtpu_header_length_parser
    import gtpu_hlp_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = MAX_HEADER_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pkt_valid,
    output logic      pkt_stall,
    input  pkt_word_t pkt_word,
    output logic      hdr_valid,
    input  logic      hdr_stall,
    output hdr_word_t hdr_word
);

    logic       word_valid;
    pkt_word_t  word;
    logic       ready;
    logic       fire;
    parse_res_t res;

    assign fire = word_valid && ready;

    gtpu_hlp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_valid  (pkt_valid),
        .pkt_stall  (pkt_stall),
        .pkt_word   (pkt_word),
        .take       (ready),
        .word_valid (word_valid),
        .word       (word)
    );

    gtpu_hlp_parse #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .word  (word),
        .res   (res)
    );

    gtpu_hlp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .ready     (ready),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr_word  (hdr_word)
    );

endmodule

// ===== design/gtpu_hlp_checker.sv =====
// gtpu_hlp_checker: port-level checks of the header length parser, with bind
// depends on gtpu_hlp_pkg and gtpu_header_length_parser

module gtpu_hlp_checker
    import gtpu_hlp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pkt_valid,
    input logic      pkt_stall,
    input pkt_word_t pkt_word,
    input logic      hdr_valid,
    input logic      hdr_stall,
    input hdr_word_t hdr_word
);

    // stalled packet word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_stall |=> pkt_valid && $stable(pkt_word))
    else $error("packet word changed while stalled");

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_stall |=> hdr_valid && $stable(hdr_word))
    else $error("result word changed while stalled");

    // failed parse reports no length
    assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_word.status != ST_OK |-> hdr_word.header_length == '0)
    else $error("length given with error status");

    // no option flags means the plain fixed header
    assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_word.status == ST_OK && hdr_word.option_flags == 3'd0
        |-> hdr_word.header_length == LEN_W'(FIXED_LEN))
    else $error("plain header length wrong");

    // flags without extension means the optional-field header
    assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_word.status == ST_OK && hdr_word.option_flags != 3'd0
        && !hdr_word.option_flags[2]
        |-> hdr_word.header_length == LEN_W'(FIXED_OPT_LEN))
    else $error("optional-field header length wrong");

endmodule

bind gtpu_header_length_parser gtpu_hlp_checker u_chk (.*);
